[src/ost_pkg.sv]
`default_nettype none
package ost_pkg;

	// Table geometry.
	localparam int CAPACITY    = 256;
	localparam int VALUE_WIDTH = 32;
	localparam int ADDR_W      = $clog2(CAPACITY);
	localparam int CNT_W       = ADDR_W + 1;
	localparam int CNT1_W      = CNT_W + 1;

	// Port field widths.
	localparam int OP_W     = 3;
	localparam int POS_W    = 9;
	localparam int IVAL_W   = 32;
	localparam int STATUS_W = 2;
	localparam int RPOS_W   = 8;
	localparam int RVAL_W   = 32;
	localparam int LEN_W    = 9;

	// Common width for position against count comparisons.
	localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT_AT     = 3'd0,
		OP_INSERT_SORTED = 3'd1,
		OP_ERASE         = 3'd2,
		OP_REMOVE_ALL    = 3'd3,
		OP_GET           = 3'd4,
		OP_SET           = 3'd5,
		OP_FIND          = 3'd6
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_BAD_POS   = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		RA_IDX,
		RA_IDX_M1,
		RA_IDX_P1,
		RA_POS
	} rd_sel_t;

	typedef enum logic [1:0] {
		WA_IDX,
		WA_POS,
		WA_WP
	} wa_sel_t;

	typedef enum logic {
		WD_RDATA,
		WD_VAL
	} wd_sel_t;

	typedef enum logic [2:0] {
		IDX_HOLD,
		IDX_POS,
		IDX_CNT,
		IDX_INC,
		IDX_DEC
	} idx_op_t;

	typedef enum logic [1:0] {
		CNT_HOLD,
		CNT_INC,
		CNT_DEC,
		CNT_WP
	} cnt_op_t;

	typedef enum logic [1:0] {
		RP_HOLD,
		RP_POS,
		RP_IDX
	} rpos_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic      load;
		logic      rd_en;
		rd_sel_t   rd_sel;
		logic      wr_en;
		wa_sel_t   wa_sel;
		wd_sel_t   wd_sel;
		idx_op_t   idx_op;
		logic      pos_from_idx;
		cnt_op_t   cnt_op;
		logic      wp_inc;
		logic      rem_inc;
		logic      st_load;
		status_t   st_code;
		rpos_sel_t rpos_sel;
		logic      rval_load;
		logic      out_load;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		op_t  op;
		logic full;
		logic pos_gt_cnt;
		logic pos_ge_cnt;
		logic idx_lt_cnt;
		logic idx_gt_pos;
		logic idx1_lt_cnt;
		logic rd_lt_val;
		logic rd_eq_val;
	} dp_stat_t;

endpackage
`default_nettype wire

[src/ordered_sequence_table_core.sv]
// Ordered sequence table: a bounded list of up to CAPACITY unsigned words.
// Input channel (in_valid / in_stall) carries one request beat: operation,
// position and item_value. Output channel (out_valid / out_stall) carries one
// result beat per request: status, result_position, read_value,
// removed_count and list_length after the request.
// Requests are processed one at a time; in_stall is high from acceptance
// until the result is moved into the output register.
// Insert_at and erase move the entries behind the position, find and
// remove_all visit at most every entry held, and insert_sorted searches
// and then moves. The next request is accepted in the cycle the previous
// result is first offered. The entry table gives one access per cycle with
// registered read data, so each moved or visited entry is first read and
// then compared or written.
// The output register holds a result while out_stall is high; a new request
// is accepted meanwhile, and its result waits until the register is free.
// Reset (arst_n low) empties the list and drops any pending result; no
// clearing pass is needed since only entries below the length are read.
`default_nettype none
module ordered_sequence_table_core import ost_pkg::*; (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_stall,
	input  wire [OP_W-1:0]       operation,
	input  wire [POS_W-1:0]      position,
	input  wire [IVAL_W-1:0]     item_value,
	output logic                 out_valid,
	input  wire                  out_stall,
	output logic [STATUS_W-1:0]  status,
	output logic [RPOS_W-1:0]    result_position,
	output logic [RVAL_W-1:0]    read_value,
	output logic [LEN_W-1:0]     removed_count,
	output logic [LEN_W-1:0]     list_length
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// Request sequencer.
	ost_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Entry table, counters and result registers.
	ost_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.operation       (operation),
		.position        (position),
		.item_value      (item_value),
		.stat            (stat),
		.status          (status),
		.result_position (result_position),
		.read_value      (read_value),
		.removed_count   (removed_count),
		.list_length     (list_length)
	);

endmodule
`default_nettype wire

[src/ost_datapath.sv]
`default_nettype none
module ost_datapath import ost_pkg::*; (
	input  wire                  clk,
	input  wire                  arst_n,
	input  dp_cmd_t              cmd,
	input  wire [OP_W-1:0]       operation,
	input  wire [POS_W-1:0]      position,
	input  wire [IVAL_W-1:0]     item_value,
	output dp_stat_t             stat,
	output logic [STATUS_W-1:0]  status,
	output logic [RPOS_W-1:0]    result_position,
	output logic [RVAL_W-1:0]    read_value,
	output logic [LEN_W-1:0]     removed_count,
	output logic [LEN_W-1:0]     list_length
);

	logic [VALUE_WIDTH-1:0] mem_q [CAPACITY];
	logic [VALUE_WIDTH-1:0] rdata_q;

	op_t                    op_q;
	logic [POS_W-1:0]       pos_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [CNT_W-1:0]       idx_q;
	logic [CNT_W-1:0]       wp_q;
	logic [CNT_W-1:0]       rem_q;
	status_t                res_status_q;
	logic [ADDR_W-1:0]      res_rpos_q;
	logic [VALUE_WIDTH-1:0] res_rval_q;

	logic [STATUS_W-1:0]    out_status_q;
	logic [RPOS_W-1:0]      out_rpos_q;
	logic [RVAL_W-1:0]      out_rval_q;
	logic [LEN_W-1:0]       out_removed_q;
	logic [LEN_W-1:0]       out_length_q;

	logic [CNT_W-1:0]       idx_m1;
	logic [CNT_W-1:0]       idx_p1;
	logic [CNT1_W-1:0]      idx_p1_wide;
	logic [CMP_W-1:0]       pos_ext;
	logic [CMP_W-1:0]       cnt_ext;
	logic [CMP_W-1:0]       idx_ext;
	logic [ADDR_W-1:0]      rd_addr;
	logic [ADDR_W-1:0]      wr_addr;
	logic [VALUE_WIDTH-1:0] wr_data;

	// Neighbor indexes and widened operands for the comparisons.
	assign idx_m1      = idx_q - CNT_W'(1);
	assign idx_p1      = idx_q + CNT_W'(1);
	assign idx_p1_wide = CNT1_W'(idx_q) + CNT1_W'(1);
	assign pos_ext     = CMP_W'(pos_q);
	assign cnt_ext     = CMP_W'(cnt_q);
	assign idx_ext     = CMP_W'(idx_q);

	// Status toward the controller.
	always_comb begin
		stat.op          = op_q;
		stat.full        = (cnt_q == CNT_W'(CAPACITY));
		stat.pos_gt_cnt  = (pos_ext > cnt_ext);
		stat.pos_ge_cnt  = (pos_ext >= cnt_ext);
		stat.idx_lt_cnt  = (idx_q < cnt_q);
		stat.idx_gt_pos  = (idx_ext > pos_ext);
		stat.idx1_lt_cnt = (idx_p1_wide < CNT1_W'(cnt_q));
		stat.rd_lt_val   = (rdata_q < val_q);
		stat.rd_eq_val   = (rdata_q == val_q);
	end

	// Table address and write data selection.
	always_comb begin
		case (cmd.rd_sel)
			RA_IDX:    rd_addr = idx_q[ADDR_W-1:0];
			RA_IDX_M1: rd_addr = idx_m1[ADDR_W-1:0];
			RA_IDX_P1: rd_addr = idx_p1[ADDR_W-1:0];
			RA_POS:    rd_addr = ADDR_W'(pos_q);
			default:   rd_addr = idx_q[ADDR_W-1:0];
		endcase
		case (cmd.wa_sel)
			WA_IDX:  wr_addr = idx_q[ADDR_W-1:0];
			WA_POS:  wr_addr = ADDR_W'(pos_q);
			WA_WP:   wr_addr = wp_q[ADDR_W-1:0];
			default: wr_addr = idx_q[ADDR_W-1:0];
		endcase
		case (cmd.wd_sel)
			WD_RDATA: wr_data = rdata_q;
			WD_VAL:   wr_data = val_q;
			default:  wr_data = rdata_q;
		endcase
	end

	// Entry table: one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem_q[rd_addr];
		end
	end

	// Walk index, write pointer, removal count and list length.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q  <= OP_GET;
			cnt_q <= '0;
			idx_q <= '0;
			wp_q  <= '0;
			rem_q <= '0;
		end else begin
			if (cmd.load) begin
				op_q  <= op_t'(operation);
				idx_q <= '0;
				wp_q  <= '0;
				rem_q <= '0;
			end else begin
				case (cmd.idx_op)
					IDX_HOLD: idx_q <= idx_q;
					IDX_POS:  idx_q <= CNT_W'(pos_q);
					IDX_CNT:  idx_q <= cnt_q;
					IDX_INC:  idx_q <= idx_p1;
					IDX_DEC:  idx_q <= idx_m1;
					default:  idx_q <= idx_q;
				endcase
				if (cmd.wp_inc) begin
					wp_q <= wp_q + CNT_W'(1);
				end
				if (cmd.rem_inc) begin
					rem_q <= rem_q + CNT_W'(1);
				end
			end
			case (cmd.cnt_op)
				CNT_HOLD: cnt_q <= cnt_q;
				CNT_INC:  cnt_q <= cnt_q + CNT_W'(1);
				CNT_DEC:  cnt_q <= cnt_q - CNT_W'(1);
				CNT_WP:   cnt_q <= wp_q;
				default:  cnt_q <= cnt_q;
			endcase
		end
	end

	// Request operands and the result being built.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pos_q        <= position;
			val_q        <= VALUE_WIDTH'(item_value);
			res_status_q <= ST_OK;
			res_rpos_q   <= '0;
			res_rval_q   <= '0;
		end else begin
			if (cmd.pos_from_idx) begin
				pos_q <= POS_W'(idx_q);
			end
			if (cmd.st_load) begin
				res_status_q <= cmd.st_code;
			end
			case (cmd.rpos_sel)
				RP_HOLD: res_rpos_q <= res_rpos_q;
				RP_POS:  res_rpos_q <= ADDR_W'(pos_q);
				RP_IDX:  res_rpos_q <= idx_q[ADDR_W-1:0];
				default: res_rpos_q <= res_rpos_q;
			endcase
			if (cmd.rval_load) begin
				res_rval_q <= rdata_q;
			end
		end
	end

	// Output register, held while the receiver stalls.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_status_q  <= res_status_q;
			out_rpos_q    <= RPOS_W'(res_rpos_q);
			out_rval_q    <= RVAL_W'(res_rval_q);
			out_removed_q <= LEN_W'(rem_q);
			out_length_q  <= LEN_W'(cnt_q);
		end
	end

	assign status          = out_status_q;
	assign result_position = out_rpos_q;
	assign read_value      = out_rval_q;
	assign removed_count   = out_removed_q;
	assign list_length     = out_length_q;

	// The length never exceeds the table.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY))
		else $error("list length above capacity");

	// Compaction never writes ahead of the entry being read.
	a_wp_behind: assert property (@(posedge clk) disable iff (!arst_n)
		wp_q <= idx_q)
		else $error("compaction write pointer passed read index");

	// An upward shift only reads below a nonzero index.
	a_shift_rd: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.rd_en && cmd.rd_sel == RA_IDX_M1) |-> (idx_q != '0))
		else $error("shift read below entry zero");

	// The whole remove pass accounts for every entry it has visited.
	a_rm_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(op_q == OP_REMOVE_ALL && !cmd.load) |-> (wp_q + rem_q == idx_q))
		else $error("removal bookkeeping mismatch");

endmodule
`default_nettype wire

[src/ost_ctrl.sv]
`default_nettype none
module ost_ctrl import ost_pkg::*; (
	input  wire      clk,
	input  wire      arst_n,
	input  wire      in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  wire      out_stall,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_SCAN_CHK,
		S_SCAN_CMP,
		S_UP_CHK,
		S_UP_WR,
		S_DN_CHK,
		S_DN_WR,
		S_RM_CHK,
		S_RM_CMP,
		S_GET_WAIT,
		S_DONE
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	// Next state and datapath commands.
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				state_d = S_DONE;
				case (stat.op)
					OP_INSERT_AT: begin
						if (stat.full) begin
							cmd.st_load = 1'b1;
							cmd.st_code = ST_FULL;
						end else if (stat.pos_gt_cnt) begin
							cmd.st_load = 1'b1;
							cmd.st_code = ST_BAD_POS;
						end else begin
							cmd.idx_op = IDX_CNT;
							state_d    = S_UP_CHK;
						end
					end
					OP_INSERT_SORTED: begin
						if (stat.full) begin
							cmd.st_load = 1'b1;
							cmd.st_code = ST_FULL;
						end else begin
							state_d = S_SCAN_CHK;
						end
					end
					OP_ERASE: begin
						if (stat.pos_ge_cnt) begin
							cmd.st_load = 1'b1;
							cmd.st_code = ST_BAD_POS;
						end else begin
							cmd.idx_op = IDX_POS;
							state_d    = S_DN_CHK;
						end
					end
					OP_REMOVE_ALL: begin
						state_d = S_RM_CHK;
					end
					OP_GET: begin
						if (stat.pos_ge_cnt) begin
							cmd.st_load = 1'b1;
							cmd.st_code = ST_BAD_POS;
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = RA_POS;
							state_d    = S_GET_WAIT;
						end
					end
					OP_SET: begin
						if (stat.pos_ge_cnt) begin
							cmd.st_load = 1'b1;
							cmd.st_code = ST_BAD_POS;
						end else begin
							cmd.wr_en  = 1'b1;
							cmd.wa_sel = WA_POS;
							cmd.wd_sel = WD_VAL;
						end
					end
					OP_FIND: begin
						state_d = S_SCAN_CHK;
					end
					default: begin
						cmd.st_load = 1'b1;
						cmd.st_code = ST_BAD_POS;
					end
				endcase
			end
			// Linear search for sorted insert and find.
			S_SCAN_CHK: begin
				if (stat.idx_lt_cnt) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RA_IDX;
					state_d    = S_SCAN_CMP;
				end else if (stat.op == OP_FIND) begin
					cmd.st_load = 1'b1;
					cmd.st_code = ST_NOT_FOUND;
					state_d     = S_DONE;
				end else begin
					cmd.pos_from_idx = 1'b1;
					cmd.idx_op       = IDX_CNT;
					state_d          = S_UP_CHK;
				end
			end
			S_SCAN_CMP: begin
				if (stat.op == OP_FIND) begin
					if (stat.rd_eq_val) begin
						cmd.rpos_sel = RP_IDX;
						state_d      = S_DONE;
					end else begin
						cmd.idx_op = IDX_INC;
						state_d    = S_SCAN_CHK;
					end
				end else if (stat.rd_lt_val) begin
					cmd.idx_op = IDX_INC;
					state_d    = S_SCAN_CHK;
				end else begin
					cmd.pos_from_idx = 1'b1;
					cmd.idx_op       = IDX_CNT;
					state_d          = S_UP_CHK;
				end
			end
			// Open a slot by moving entries up, last entry first.
			S_UP_CHK: begin
				if (stat.idx_gt_pos) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RA_IDX_M1;
					state_d    = S_UP_WR;
				end else begin
					cmd.wr_en    = 1'b1;
					cmd.wa_sel   = WA_POS;
					cmd.wd_sel   = WD_VAL;
					cmd.cnt_op   = CNT_INC;
					cmd.rpos_sel = RP_POS;
					state_d      = S_DONE;
				end
			end
			S_UP_WR: begin
				cmd.wr_en  = 1'b1;
				cmd.wa_sel = WA_IDX;
				cmd.wd_sel = WD_RDATA;
				cmd.idx_op = IDX_DEC;
				state_d    = S_UP_CHK;
			end
			// Close the gap left by an erase.
			S_DN_CHK: begin
				if (stat.idx1_lt_cnt) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RA_IDX_P1;
					state_d    = S_DN_WR;
				end else begin
					cmd.cnt_op = CNT_DEC;
					state_d    = S_DONE;
				end
			end
			S_DN_WR: begin
				cmd.wr_en  = 1'b1;
				cmd.wa_sel = WA_IDX;
				cmd.wd_sel = WD_RDATA;
				cmd.idx_op = IDX_INC;
				state_d    = S_DN_CHK;
			end
			// Compact the list, dropping every matching entry.
			S_RM_CHK: begin
				if (stat.idx_lt_cnt) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RA_IDX;
					state_d    = S_RM_CMP;
				end else begin
					cmd.cnt_op = CNT_WP;
					state_d    = S_DONE;
				end
			end
			S_RM_CMP: begin
				if (stat.rd_eq_val) begin
					cmd.rem_inc = 1'b1;
				end else begin
					cmd.wr_en  = 1'b1;
					cmd.wa_sel = WA_WP;
					cmd.wd_sel = WD_RDATA;
					cmd.wp_inc = 1'b1;
				end
				cmd.idx_op = IDX_INC;
				state_d    = S_RM_CHK;
			end
			S_GET_WAIT: begin
				cmd.rval_load = 1'b1;
				state_d       = S_DONE;
			end
			// Hand the result to the output register once it is free.
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= cmd.out_load || (out_valid_q && out_stall);
		end
	end

	// A loaded result is offered on the next cycle.
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid_q)
		else $error("result loaded but not offered");

	// A finished request waits while the previous result is still stalled.
	a_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_valid_q && out_stall) |=> (state_q == S_DONE))
		else $error("result register overwritten while stalled");

	// An accepted beat is dispatched on the next cycle.
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == S_DISPATCH))
		else $error("accepted beat not dispatched");

endmodule
`default_nettype wire

[tb/tb_ordered_sequence_table_core.sv]
`timescale 1ns / 1ps
module tb_ordered_sequence_table_core;
	import ost_pkg::*;

	localparam logic [OP_W-1:0] OP_UNDEFINED = 3'd7;
	localparam int DIRECTED_ROWS  = 25;
	localparam int FULL_ROWS      = 10;
	localparam int RAND_PER_PHASE = 300;
	localparam int HOLD_CYCLES    = 1500;
	localparam int DRAIN_CYCLES   = 2 * CAPACITY + 16;
	localparam int LIMIT_CYCLES   = 3_000_000;

	// One result beat as the list reports it.
	typedef struct packed {
		status_t           status;
		logic [RPOS_W-1:0] rpos;
		logic [RVAL_W-1:0] rval;
		logic [LEN_W-1:0]  removed;
		logic [LEN_W-1:0]  len;
	} list_result_t;

	// One request beat, with an optional hand-written expectation.
	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [POS_W-1:0]  pos;
		logic [IVAL_W-1:0] val;
		logic              typed;
		list_result_t      exp;
	} stim_row_t;

	localparam list_result_t NO_EXP = '{ST_OK, 8'd0, 32'd0, 9'd0, 9'd0};

	logic                clk;
	logic                arst_n     = 1'b0;
	logic                in_valid   = 1'b0;
	logic                in_stall;
	logic [OP_W-1:0]     operation  = '0;
	logic [POS_W-1:0]    position   = '0;
	logic [IVAL_W-1:0]   item_value = '0;
	logic                out_valid;
	logic                out_stall  = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [RPOS_W-1:0]   result_position;
	logic [RVAL_W-1:0]   read_value;
	logic [LEN_W-1:0]    removed_count;
	logic [LEN_W-1:0]    list_length;

	// Predicted contents of the list.
	logic [VALUE_WIDTH-1:0] list_mem [CAPACITY];
	int unsigned            list_len = 0;

	list_result_t   pending_results [$];
	stim_row_t      dir_rows [DIRECTED_ROWS];
	stim_row_t      full_rows [FULL_ROWS];
	logic [31:0]    value_pool [8];
	int             mismatches  = 0;
	int             tx_idle_pct = 0;
	int             rx_idle_pct = 0;
	logic           hold_req    = 1'b0;

	ordered_sequence_table_core dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.operation       (operation),
		.position        (position),
		.item_value      (item_value),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.result_position (result_position),
		.read_value      (read_value),
		.removed_count   (removed_count),
		.list_length     (list_length)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Open a slot at the given index by moving later entries up one place.
	function automatic void list_open_slot(input int unsigned at, input logic [31:0] v);
		int unsigned k;
		for (k = list_len; k > at; k--) begin
			list_mem[k] = list_mem[k - 1];
		end
		list_mem[at] = v;
		list_len++;
	endfunction

	// Apply one request to the predicted list and return the result it causes.
	function automatic list_result_t list_apply(input logic [OP_W-1:0] op,
			input logic [POS_W-1:0] pos, input logic [IVAL_W-1:0] val);
		list_result_t r;
		int unsigned  k;
		int unsigned  w;
		r = NO_EXP;
		case (op)
			OP_INSERT_AT: begin
				if (list_len >= CAPACITY) begin
					r.status = ST_FULL;
				end else if (pos > list_len) begin
					r.status = ST_BAD_POS;
				end else begin
					list_open_slot(pos, val);
					r.rpos = pos[RPOS_W-1:0];
				end
			end
			OP_INSERT_SORTED: begin
				if (list_len >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					k = 0;
					while (k < list_len && list_mem[k] < val) k++;
					list_open_slot(k, val);
					r.rpos = k[RPOS_W-1:0];
				end
			end
			OP_ERASE: begin
				if (pos >= list_len) begin
					r.status = ST_BAD_POS;
				end else begin
					for (k = pos; k + 1 < list_len; k++) list_mem[k] = list_mem[k + 1];
					list_len--;
				end
			end
			OP_REMOVE_ALL: begin
				w = 0;
				for (k = 0; k < list_len; k++) begin
					if (list_mem[k] == val) begin
						r.removed = r.removed + 1'b1;
					end else begin
						list_mem[w] = list_mem[k];
						w++;
					end
				end
				list_len = w;
			end
			OP_GET: begin
				if (pos >= list_len) r.status = ST_BAD_POS;
				else r.rval = list_mem[pos];
			end
			OP_SET: begin
				if (pos >= list_len) r.status = ST_BAD_POS;
				else list_mem[pos] = val;
			end
			OP_FIND: begin
				r.status = ST_NOT_FOUND;
				for (k = 0; k < list_len; k++) begin
					if (list_mem[k] == val) begin
						r.status = ST_OK;
						r.rpos = k[RPOS_W-1:0];
						break;
					end
				end
			end
			default: begin
				r.status = ST_BAD_POS;
			end
		endcase
		r.len = list_len[LEN_W-1:0];
		return r;
	endfunction

	// Offer one request beat, idling first at random, and record its expectation.
	task automatic offer_request(input stim_row_t row);
		list_result_t predicted;
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		operation  <= row.op;
		position   <= row.pos;
		item_value <= row.val;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predicted = list_apply(row.op, row.pos, row.val);
		pending_results.push_back(row.typed ? row.exp : predicted);
	endtask

	// Receiver: random stall, plus one long hold-off on request.
	initial begin
		logic hold_served;
		int   n;
		hold_served = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_served) begin
				hold_served = 1'b1;
				for (n = 0; n < HOLD_CYCLES; n++) begin
					out_stall <= 1'b1;
					@(posedge clk);
				end
			end
			out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
		end
	end

	// Compare each result beat with the oldest expectation.
	always @(posedge clk) begin
		list_result_t want;
		list_result_t got;
		if (arst_n && out_valid && !out_stall) begin
			got = {status, result_position, read_value, removed_count, list_length};
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected result beat: st=%0d pos=%0d val=%h rem=%0d len=%0d",
						got.status, got.rpos, got.rval, got.removed, got.len);
				end
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch: expected st=%0d pos=%0d val=%h rem=%0d len=%0d",
							want.status, want.rpos, want.rval, want.removed, want.len);
						$display("          actual   st=%0d pos=%0d val=%h rem=%0d len=%0d",
							got.status, got.rpos, got.rval, got.removed, got.len);
					end
				end
			end
		end
	end

	// Watchdog on the whole run.
	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("tb_ordered_sequence_table_core failed");
		$finish;
	end

	// Stimulus: directed table, then three random phases with different idling.
	initial begin
		stim_row_t         row;
		logic [OP_W-1:0]   op;
		logic [POS_W-1:0]  pos;
		logic [IVAL_W-1:0] val;
		int                ph;
		int                n;
		int                pick;
		int                i;

		// Empty list, the value extremes, every operation and the position and not-found refusals.
		dir_rows[0]  = '{OP_GET, 9'd0, 32'd0, 1'b1, '{ST_BAD_POS, 8'd0, 32'd0, 9'd0, 9'd0}};
		dir_rows[1]  = '{OP_ERASE, 9'd0, 32'd0, 1'b1, '{ST_BAD_POS, 8'd0, 32'd0, 9'd0, 9'd0}};
		dir_rows[2]  = '{OP_SET, 9'd0, 32'hDEADBEEF, 1'b1,
			'{ST_BAD_POS, 8'd0, 32'd0, 9'd0, 9'd0}};
		dir_rows[3]  = '{OP_FIND, 9'd0, 32'd0, 1'b1, '{ST_NOT_FOUND, 8'd0, 32'd0, 9'd0, 9'd0}};
		dir_rows[4]  = '{OP_REMOVE_ALL, 9'd0, 32'd0, 1'b1, '{ST_OK, 8'd0, 32'd0, 9'd0, 9'd0}};
		dir_rows[5]  = '{OP_INSERT_AT, 9'd1, 32'd5, 1'b1,
			'{ST_BAD_POS, 8'd0, 32'd0, 9'd0, 9'd0}};
		dir_rows[6]  = '{OP_INSERT_AT, 9'd0, 32'hFFFFFFFF, 1'b1,
			'{ST_OK, 8'd0, 32'd0, 9'd0, 9'd1}};
		dir_rows[7]  = '{OP_INSERT_AT, 9'd0, 32'd0, 1'b1, '{ST_OK, 8'd0, 32'd0, 9'd0, 9'd2}};
		dir_rows[8]  = '{OP_INSERT_SORTED, 9'd0, 32'h80000000, 1'b0, NO_EXP};
		// An equal entry is not smaller, so the new value goes in front of it.
		dir_rows[9]  = '{OP_INSERT_SORTED, 9'd0, 32'd0, 1'b0, NO_EXP};
		dir_rows[10] = '{OP_INSERT_SORTED, 9'd0, 32'hFFFFFFFF, 1'b0, NO_EXP};
		dir_rows[11] = '{OP_INSERT_AT, 9'd5, 32'h12345678, 1'b0, NO_EXP};
		dir_rows[12] = '{OP_GET, 9'd5, 32'd0, 1'b0, NO_EXP};
		dir_rows[13] = '{OP_GET, 9'd6, 32'd0, 1'b1, '{ST_BAD_POS, 8'd0, 32'd0, 9'd0, 9'd6}};
		dir_rows[14] = '{OP_SET, 9'd2, 32'hA5A5A5A5, 1'b0, NO_EXP};
		dir_rows[15] = '{OP_GET, 9'd2, 32'd0, 1'b0, NO_EXP};
		dir_rows[16] = '{OP_FIND, 9'd0, 32'hFFFFFFFF, 1'b0, NO_EXP};
		dir_rows[17] = '{OP_FIND, 9'd0, 32'd1, 1'b1,
			'{ST_NOT_FOUND, 8'd0, 32'd0, 9'd0, 9'd6}};
		dir_rows[18] = '{OP_INSERT_AT, 9'd256, 32'h5A5A5A5A, 1'b1,
			'{ST_BAD_POS, 8'd0, 32'd0, 9'd0, 9'd6}};
		dir_rows[19] = '{OP_GET, 9'd256, 32'd0, 1'b1, '{ST_BAD_POS, 8'd0, 32'd0, 9'd0, 9'd6}};
		dir_rows[20] = '{OP_REMOVE_ALL, 9'd0, 32'd0, 1'b0, NO_EXP};
		dir_rows[21] = '{OP_ERASE, 9'd0, 32'd0, 1'b0, NO_EXP};
		dir_rows[22] = '{OP_REMOVE_ALL, 9'd0, 32'hFFFFFFFF, 1'b0, NO_EXP};
		dir_rows[23] = '{OP_UNDEFINED, 9'd0, 32'd0, 1'b1,
			'{ST_BAD_POS, 8'd0, 32'd0, 9'd0, 9'd1}};
		dir_rows[24] = '{OP_ERASE, 9'd0, 32'd0, 1'b0, NO_EXP};

		// Probes of a full list; fullness is checked ahead of the position.
		full_rows[0] = '{OP_INSERT_AT, 9'd256, 32'd0, 1'b0, NO_EXP};
		full_rows[1] = '{OP_INSERT_AT, 9'd0, 32'hFFFFFFFF, 1'b0, NO_EXP};
		full_rows[2] = '{OP_INSERT_SORTED, 9'd0, 32'd0, 1'b0, NO_EXP};
		full_rows[3] = '{OP_GET, 9'd255, 32'd0, 1'b0, NO_EXP};
		full_rows[4] = '{OP_SET, 9'd255, 32'hFFFFFFFF, 1'b0, NO_EXP};
		full_rows[5] = '{OP_FIND, 9'd0, 32'hFFFFFFFF, 1'b0, NO_EXP};
		full_rows[6] = '{OP_ERASE, 9'd256, 32'd0, 1'b0, NO_EXP};
		full_rows[7] = '{OP_ERASE, 9'd0, 32'd0, 1'b0, NO_EXP};
		full_rows[8] = '{OP_INSERT_SORTED, 9'd0, 32'h80000000, 1'b0, NO_EXP};
		full_rows[9] = '{OP_GET, 9'd256, 32'd0, 1'b0, NO_EXP};

		// A small pool of values keeps find and remove_all hitting entries.
		value_pool[0] = 32'h00000000;
		value_pool[1] = 32'hFFFFFFFF;
		value_pool[2] = 32'h00000001;
		value_pool[3] = 32'h80000000;
		for (i = 4; i < 8; i++) value_pool[i] = $urandom;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		tx_idle_pct = 23;
		rx_idle_pct = 86;
		for (i = 0; i < DIRECTED_ROWS; i++) offer_request(dir_rows[i]);

		for (ph = 0; ph < 3; ph++) begin
			tx_idle_pct = (ph == 0) ? 23 : (ph == 1) ? 86 : 0;
			rx_idle_pct = (ph == 0) ? 86 : (ph == 1) ? 23 : 0;
			for (n = 0; n < RAND_PER_PHASE; n++) begin
				if (ph == 0 && n == 100) hold_req <= 1'b1;

				// Fill the list to capacity, probe it, then empty it again.
				if (ph == 2 && n == 50) begin
					while (list_len < CAPACITY) begin
						row = '{OP_INSERT_AT, 9'(list_len), value_pool[$urandom_range(0, 3)],
							1'b0, NO_EXP};
						offer_request(row);
					end
					for (i = 0; i < FULL_ROWS; i++) offer_request(full_rows[i]);
					while (list_len > 0) begin
						row = '{OP_REMOVE_ALL, 9'd0, list_mem[0], 1'b0, NO_EXP};
						offer_request(row);
					end
				end

				// Random request, mostly with a position inside the list.
				pick = $urandom_range(0, 99);
				if (pick < 20) op = OP_INSERT_AT;
				else if (pick < 35) op = OP_INSERT_SORTED;
				else if (pick < 50) op = OP_ERASE;
				else if (pick < 58) op = OP_REMOVE_ALL;
				else if (pick < 72) op = OP_GET;
				else if (pick < 84) op = OP_SET;
				else if (pick < 98) op = OP_FIND;
				else op = OP_UNDEFINED;
				// Keep the list short so that each request stays cheap.
				if (list_len > 40 && (op == OP_INSERT_AT || op == OP_INSERT_SORTED) &&
						$urandom_range(0, 9) < 6) begin
					op = OP_ERASE;
				end
				if ($urandom_range(0, 99) < 85) begin
					if (op == OP_INSERT_AT) pos = 9'($urandom_range(0, list_len));
					else if (list_len == 0) pos = '0;
					else pos = 9'($urandom_range(0, list_len - 1));
				end else begin
					pos = 9'($urandom_range(0, CAPACITY));
				end
				if ($urandom_range(0, 99) < 75) val = value_pool[$urandom_range(0, 7)];
				else val = $urandom;
				if ($urandom_range(0, 99) < 3) value_pool[$urandom_range(2, 7)] = $urandom;
				row = '{op, pos, val, 1'b0, NO_EXP};
				offer_request(row);
			end
		end
		in_valid <= 1'b0;

		// Drain the outstanding results, then watch for stray beats.
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("tb_ordered_sequence_table_core passed");
		end else begin
			$display("tb_ordered_sequence_table_core failed");
		end
		$finish;
	end

endmodule

[sim.f]
src/ost_pkg.sv
src/ost_datapath.sv
src/ost_ctrl.sv
src/ordered_sequence_table_core.sv
tb/tb_ordered_sequence_table_core.sv
